### src/box_overlay_corner_brackets_core_defines.svh
// Assertion macros shared by the box overlay RTL.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef BOX_OVERLAY_CORNER_BRACKETS_CORE_DEFINES_SVH
`define BOX_OVERLAY_CORNER_BRACKETS_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BOCB_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BOCB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bocb_pkg.sv
// Shared types and constants of the box overlay block.
// No dependencies; every other file but the assertion macro header imports it.
package bocb_pkg;

  localparam int unsigned PIX_BITS     = 11;
  localparam int unsigned FRAME_BITS   = 12;
  localparam int unsigned CFG_IDX_BITS = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_POINT_ONE    = 3'd0,
    CFG_POINT_TWO    = 3'd1,
    CFG_POINT_THREE  = 3'd2,
    CFG_POINT_FOUR   = 3'd3,
    CFG_WARN_COLOR   = 3'd4,
    CFG_FRAME_WIDTH  = 3'd5,
    CFG_FRAME_HEIGHT = 3'd6
  } cfg_idx_e;

  // Incoming pixel request
  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_x;
    logic [PIX_BITS-1:0] pixel_y;
    logic [7:0]          byte_zero;
    logic [7:0]          byte_one;
    logic [7:0]          byte_two;
  } pix_t;

  // Outgoing color
  typedef struct packed {
    logic [7:0] out_zero;
    logic [7:0] out_one;
    logic [7:0] out_two;
  } rgb_t;

endpackage

### src/bocb_pixel_if.sv
// Valid/ready channel carrying one pixel request.
// Depends on bocb_pkg for the payload type.
interface bocb_pixel_if import bocb_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/bocb_color_if.sv
// Valid/ready channel carrying one output color.
// Depends on bocb_pkg for the payload type.
interface bocb_color_if import bocb_pkg::*; ();
  logic valid;
  logic ready;
  rgb_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/bocb_box.sv
// Stages one and two: box extents from the corner points, frame check, shorter side.
// Depends on bocb_pkg and the assertion macro header.
`include "box_overlay_corner_brackets_core_defines.svh"

module bocb_box import bocb_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  pix_t                                   pix_i,
  input  logic [3:0][2*COORD_BITS-1:0]           point_i,
  input  logic [FRAME_BITS-1:0]                  frame_w_i,
  input  logic [FRAME_BITS-1:0]                  frame_h_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output pix_t                                   pix_o,
  output logic                                   box_ok_o,
  output logic [COORD_BITS-2:0]                  bx_o,
  output logic [COORD_BITS-2:0]                  ex_o,
  output logic [COORD_BITS-2:0]                  by_o,
  output logic [COORD_BITS-2:0]                  ey_o,
  output logic [COORD_BITS-2:0]                  side_o
);

  localparam int unsigned U     = COORD_BITS - 1;
  localparam int unsigned CMP_W = (U > FRAME_BITS) ? U : FRAME_BITS;

  function automatic logic signed [COORD_BITS-1:0] smin(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] smax(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  logic signed [COORD_BITS-1:0] xs [4];
  logic signed [COORD_BITS-1:0] ys [4];
  logic signed [COORD_BITS-1:0] bx_d, ex_d, by_d, ey_d;
  logic signed [COORD_BITS-1:0] bx1_q, ex1_q, by1_q, ey1_q;
  logic                         v1_q, v2_q;
  logic                         ready1, ready2;
  pix_t                         pix1_q, pix2_q;
  logic [U-1:0]                 rw, rh, side_d;
  logic                         ok_d, ok2_q;
  logic [U-1:0]                 bx2_q, ex2_q, by2_q, ey2_q, side2_q;

  // Stage one: min/max over the four corners
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xs[i] = point_i[i][COORD_BITS-1:0];
      ys[i] = point_i[i][2*COORD_BITS-1:COORD_BITS];
    end
    bx_d = smin(smin(xs[0], xs[1]), smin(xs[2], xs[3]));
    ex_d = smax(smax(xs[0], xs[1]), smax(xs[2], xs[3]));
    by_d = smin(smin(ys[0], ys[1]), smin(ys[2], ys[3]));
    ey_d = smax(smax(ys[0], ys[1]), smax(ys[2], ys[3]));
  end

  assign ready1     = !v1_q || ready2;
  assign ready2     = !v2_q || out_ready_i;
  assign in_ready_o = ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready1) begin
      pix1_q <= pix_i;
      bx1_q  <= bx_d;
      ex1_q  <= ex_d;
      by1_q  <= by_d;
      ey1_q  <= ey_d;
    end
  end

  // Stage two: frame bounds, zero-size check, shorter side
  always_comb begin
    rw     = ex1_q[U-1:0] - bx1_q[U-1:0];
    rh     = ey1_q[U-1:0] - by1_q[U-1:0];
    side_d = (rw < rh) ? rw : rh;
    ok_d   = !bx1_q[COORD_BITS-1] && !by1_q[COORD_BITS-1]
          && !ex1_q[COORD_BITS-1] && !ey1_q[COORD_BITS-1]
          && (CMP_W'(ex1_q[U-1:0]) < CMP_W'(frame_w_i))
          && (CMP_W'(ey1_q[U-1:0]) < CMP_W'(frame_h_i))
          && (rw != '0) && (rh != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && ready2) begin
      pix2_q  <= pix1_q;
      ok2_q   <= ok_d;
      bx2_q   <= bx1_q[U-1:0];
      ex2_q   <= ex1_q[U-1:0];
      by2_q   <= by1_q[U-1:0];
      ey2_q   <= ey1_q[U-1:0];
      side2_q <= side_d;
    end
  end

  assign out_valid_o = v2_q;
  assign pix_o       = pix2_q;
  assign box_ok_o    = ok2_q;
  assign bx_o        = bx2_q;
  assign ex_o        = ex2_q;
  assign by_o        = by2_q;
  assign ey_o        = ey2_q;
  assign side_o      = side2_q;

  // A box that passes the check has positive size on both axes
  `BOCB_ASSERT_NOW(a_box_nonempty, out_valid_o && box_ok_o, (side_o != '0) && (ex_o > bx_o) && (ey_o > by_o), "accepted box has zero size")

endmodule

### src/bocb_size.sv
// Stages three and four: bracket length and thickness, then bar edge positions.
// Depends on bocb_pkg and the assertion macro header.
`include "box_overlay_corner_brackets_core_defines.svh"

module bocb_size import bocb_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_t                  pix_i,
  input  logic                  box_ok_i,
  input  logic [COORD_BITS-2:0] bx_i,
  input  logic [COORD_BITS-2:0] ex_i,
  input  logic [COORD_BITS-2:0] by_i,
  input  logic [COORD_BITS-2:0] ey_i,
  input  logic [COORD_BITS-2:0] side_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_t                  pix_o,
  output logic                  box_ok_o,
  output logic [COORD_BITS-2:0] bx_o,
  output logic [COORD_BITS-2:0] ex_o,
  output logic [COORD_BITS-2:0] by_o,
  output logic [COORD_BITS-2:0] ey_o,
  output logic [COORD_BITS-2:0] xl_len_o,
  output logic [COORD_BITS-2:0] xr_len_o,
  output logic [COORD_BITS-2:0] xl_thk_o,
  output logic [COORD_BITS-2:0] xr_thk_o,
  output logic [COORD_BITS-2:0] yt_len_o,
  output logic [COORD_BITS-2:0] yb_len_o,
  output logic [COORD_BITS-2:0] yt_thk_o,
  output logic [COORD_BITS-2:0] yb_thk_o
);

  localparam int unsigned U          = COORD_BITS - 1;
  localparam int unsigned Q          = COORD_BITS - 3;
  localparam int unsigned MUL_BITS   = 16;
  localparam int unsigned PROD_W     = COORD_BITS + MUL_BITS;
  // ceil(s/10) = (s+9)/10, division by a reciprocal exact below 2^16
  localparam int unsigned DIV10_MUL   = 52429;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam int unsigned CEIL10_BIAS = 9;
  localparam int unsigned CEIL64_BIAS = 63;
  localparam int unsigned THK_SHIFT   = 6;
  localparam int unsigned SIDE_SMALL  = 14;
  localparam int unsigned SIDE_THIN   = 64;
  localparam int unsigned LEN_MIN     = 7;
  localparam int unsigned THK_MIN     = 2;

  logic                  v3_q, v4_q;
  logic                  ready3, ready4;
  logic [COORD_BITS-1:0] n10, n64;
  logic [PROD_W-1:0]     prod;
  logic [U-1:0]          thk_big, thk_d;
  pix_t                  pix3_q, pix4_q;
  logic                  ok3_q, ok4_q, small3_q;
  logic [U-1:0]          bx3_q, ex3_q, by3_q, ey3_q, half3_q, thk3_q;
  logic [Q-1:0]          q3_q;
  logic [U-1:0]          len_d;
  logic [U-1:0]          bx4_q, ex4_q, by4_q, ey4_q;
  logic [U-1:0]          xl_len_q, xr_len_q, xl_thk_q, xr_thk_q;
  logic [U-1:0]          yt_len_q, yb_len_q, yt_thk_q, yb_thk_q;

  assign ready3     = !v3_q || ready4;
  assign ready4     = !v4_q || out_ready_i;
  assign in_ready_o = ready3;

  // Stage three: reciprocal multiply for the bracket length from the shorter side, thickness
  always_comb begin
    n10     = {1'b0, side_i} + COORD_BITS'(CEIL10_BIAS);
    n64     = {1'b0, side_i} + COORD_BITS'(CEIL64_BIAS);
    prod    = PROD_W'(n10) * PROD_W'(DIV10_MUL);
    thk_big = U'(n64 >> THK_SHIFT);
    if (side_i <= U'(SIDE_THIN) || thk_big < U'(THK_MIN)) begin
      thk_d = U'(THK_MIN);
    end else begin
      thk_d = thk_big;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ready3) begin
      v3_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready3) begin
      pix3_q   <= pix_i;
      ok3_q    <= box_ok_i;
      bx3_q    <= bx_i;
      ex3_q    <= ex_i;
      by3_q    <= by_i;
      ey3_q    <= ey_i;
      q3_q     <= prod[DIV10_SHIFT +: Q];
      small3_q <= (side_i <= U'(SIDE_SMALL));
      half3_q  <= side_i >> 1;
      thk3_q   <= thk_d;
    end
  end

  // Stage four: pick the bar length, place the bar edges
  always_comb begin
    if (small3_q) begin
      len_d = half3_q;
    end else if (q3_q < Q'(LEN_MIN)) begin
      len_d = U'(LEN_MIN);
    end else begin
      len_d = U'(q3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ready4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && ready4) begin
      pix4_q   <= pix3_q;
      ok4_q    <= ok3_q;
      bx4_q    <= bx3_q;
      ex4_q    <= ex3_q;
      by4_q    <= by3_q;
      ey4_q    <= ey3_q;
      xl_len_q <= bx3_q + len_d;
      xr_len_q <= ex3_q - len_d;
      xl_thk_q <= bx3_q + thk3_q;
      xr_thk_q <= ex3_q - thk3_q;
      yt_len_q <= by3_q + len_d;
      yb_len_q <= ey3_q - len_d;
      yt_thk_q <= by3_q + thk3_q;
      yb_thk_q <= ey3_q - thk3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign pix_o       = pix4_q;
  assign box_ok_o    = ok4_q;
  assign bx_o        = bx4_q;
  assign ex_o        = ex4_q;
  assign by_o        = by4_q;
  assign ey_o        = ey4_q;
  assign xl_len_o    = xl_len_q;
  assign xr_len_o    = xr_len_q;
  assign xl_thk_o    = xl_thk_q;
  assign xr_thk_o    = xr_thk_q;
  assign yt_len_o    = yt_len_q;
  assign yb_len_o    = yb_len_q;
  assign yt_thk_o    = yt_thk_q;
  assign yb_thk_o    = yb_thk_q;

  // Bars never reach past the opposite box edge
  `BOCB_ASSERT_NOW(a_len_in_box, out_valid_o && box_ok_o, (xl_len_o <= ex_o) && (xr_len_o >= bx_o) && (yt_len_o <= ey_o) && (yb_len_o >= by_o), "bracket length exceeds box")

endmodule

### src/bocb_paint.sv
// Stage five: bracket hit test, tint blend, output register.
// Depends on bocb_pkg and the assertion macro header.
`include "box_overlay_corner_brackets_core_defines.svh"

module bocb_paint import bocb_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  warn_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_t                  pix_i,
  input  logic                  box_ok_i,
  input  logic [COORD_BITS-2:0] bx_i,
  input  logic [COORD_BITS-2:0] ex_i,
  input  logic [COORD_BITS-2:0] by_i,
  input  logic [COORD_BITS-2:0] ey_i,
  input  logic [COORD_BITS-2:0] xl_len_i,
  input  logic [COORD_BITS-2:0] xr_len_i,
  input  logic [COORD_BITS-2:0] xl_thk_i,
  input  logic [COORD_BITS-2:0] xr_thk_i,
  input  logic [COORD_BITS-2:0] yt_len_i,
  input  logic [COORD_BITS-2:0] yb_len_i,
  input  logic [COORD_BITS-2:0] yt_thk_i,
  input  logic [COORD_BITS-2:0] yb_thk_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rgb_t                  rgb_o
);

  localparam int unsigned U           = COORD_BITS - 1;
  localparam int unsigned CW          = (U > PIX_BITS) ? U : PIX_BITS;
  localparam int unsigned BLEND_TINT  = 307;
  localparam int unsigned BLEND_KEEP  = 717;
  localparam int unsigned BLEND_SHIFT = 10;
  localparam logic [7:0]  TINT_FULL   = 8'd255;
  localparam logic [7:0]  TINT_DIM    = 8'd22;

  // 307/1024 toward the tint
  function automatic logic [7:0] blend(input logic [7:0] tint, input logic [7:0] val);
    logic [17:0] acc;
    acc = 18'(tint) * 18'(BLEND_TINT) + 18'(val) * 18'(BLEND_KEEP);
    return acc[BLEND_SHIFT +: 8];
  endfunction

  logic [CW-1:0] px, py;
  logic          inbox, bar, paint, load;
  logic          nl_len, nr_len, nl_thk, nr_thk;
  logic          nt_len, nb_len, nt_thk, nb_thk;
  rgb_t          tint, rgb_d, rgb_q;
  logic          v5_q;

  assign px = CW'(pix_i.pixel_x);
  assign py = CW'(pix_i.pixel_y);

  // Hit test: bars lie inside the box, so a bar pixel is inside and near both a vertical and a horizontal box side
  always_comb begin
    inbox  = (px >= CW'(bx_i)) && (px < CW'(ex_i)) && (py >= CW'(by_i)) && (py < CW'(ey_i));
    nl_len = px <  CW'(xl_len_i);
    nr_len = px >= CW'(xr_len_i);
    nl_thk = px <  CW'(xl_thk_i);
    nr_thk = px >= CW'(xr_thk_i);
    nt_len = py <  CW'(yt_len_i);
    nb_len = py >= CW'(yb_len_i);
    nt_thk = py <  CW'(yt_thk_i);
    nb_thk = py >= CW'(yb_thk_i);
    paint  = box_ok_i && inbox;
    bar    = ((nl_len || nr_len) && (nt_thk || nb_thk))
          || ((nl_thk || nr_thk) && (nt_len || nb_len));
  end

  // Tint and final color select
  always_comb begin
    tint.out_zero = warn_i ? TINT_FULL : TINT_DIM;
    tint.out_one  = warn_i ? TINT_DIM  : TINT_FULL;
    tint.out_two  = TINT_DIM;
    if (paint && bar) begin
      rgb_d = tint;
    end else if (paint) begin
      rgb_d.out_zero = blend(tint.out_zero, pix_i.byte_zero);
      rgb_d.out_one  = blend(tint.out_one,  pix_i.byte_one);
      rgb_d.out_two  = blend(tint.out_two,  pix_i.byte_two);
    end else begin
      rgb_d.out_zero = pix_i.byte_zero;
      rgb_d.out_one  = pix_i.byte_one;
      rgb_d.out_two  = pix_i.byte_two;
    end
  end

  assign in_ready_o = !v5_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (in_ready_o) begin
      v5_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rgb_q <= rgb_d;
    end
  end

  assign out_valid_o = v5_q;
  assign rgb_o       = rgb_q;

  // Pixels off the box come out untouched
  `BOCB_ASSERT_NEXT(a_pass_through, load && !paint, out_valid_o && (rgb_o.out_zero == $past(pix_i.byte_zero)) && (rgb_o.out_one == $past(pix_i.byte_one)) && (rgb_o.out_two == $past(pix_i.byte_two)), "pixel outside box was modified")
  // Bracket pixels carry the solid tint
  `BOCB_ASSERT_NEXT(a_bar_solid, load && paint && bar, out_valid_o && (rgb_o == $past(tint)), "bracket pixel not solid tint")

endmodule

### src/box_overlay_corner_brackets_core.sv
// Top level of the box overlay: configuration registers and the five-stage pixel pipeline.
// Depends on bocb_pkg, both channel interfaces, bocb_box, bocb_size and bocb_paint.
//
// Usage:
//   pix_in carries one pixel request (position and three color bytes) per valid/ready
//   handshake; pix_out returns the overlaid color, one result per request, in order.
//   The cfg write port sets the four corner points, the warn tint and the frame size;
//   write it only while no request is in flight.
// Pipeline: five register stages; a result is valid once its request has passed all five
//   and sits in the stage-five output register, where it waits until pix_out takes it.
// Throughput: one pixel per clock while pix_out.ready is high. Each stage has its own
//   valid bit, takes new data when empty or when its content moves on; bubbles close up.
// Stall: while pix_out.ready is low the output holds; upstream stages keep filling
//   until they are all occupied, then pix_in.ready drops. Nothing is lost or repeated.
// Reset: rst_ni clears all stage valid bits and sets the points to zero, warn off and
//   the frame to 1280 by 720.
// The division by ten for the bracket length is one 16-bit constant multiply in stage
//   three; the frame bounds check sits in stage two.
module box_overlay_corner_brackets_core import bocb_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [2*COORD_BITS-1:0]   cfg_data_i,
  bocb_pixel_if.sink                pix_in,
  bocb_color_if.source              pix_out
);

  localparam int unsigned U = COORD_BITS - 1;

  logic [3:0][2*COORD_BITS-1:0] point_q;
  logic                         warn_q;
  logic [FRAME_BITS-1:0]        frame_w_q, frame_h_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q   <= '0;
      warn_q    <= 1'b0;
      frame_w_q <= FRAME_BITS'(1280);
      frame_h_q <= FRAME_BITS'(720);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POINT_ONE:    point_q[0] <= cfg_data_i;
        CFG_POINT_TWO:    point_q[1] <= cfg_data_i;
        CFG_POINT_THREE:  point_q[2] <= cfg_data_i;
        CFG_POINT_FOUR:   point_q[3] <= cfg_data_i;
        CFG_WARN_COLOR:   warn_q     <= cfg_data_i[0];
        CFG_FRAME_WIDTH:  frame_w_q  <= cfg_data_i[FRAME_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_h_q  <= cfg_data_i[FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Box extents and frame check to bracket sizing
  logic         box_valid, box_ready, box_ok;
  pix_t         box_pix;
  logic [U-1:0] box_bx, box_ex, box_by, box_ey, box_side;

  bocb_box #(.COORD_BITS(COORD_BITS)) u_box (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .pix_i       (pix_in.data),
    .point_i     (point_q),
    .frame_w_i   (frame_w_q),
    .frame_h_i   (frame_h_q),
    .out_valid_o (box_valid),
    .out_ready_i (box_ready),
    .pix_o       (box_pix),
    .box_ok_o    (box_ok),
    .bx_o        (box_bx),
    .ex_o        (box_ex),
    .by_o        (box_by),
    .ey_o        (box_ey),
    .side_o      (box_side)
  );

  // Bracket sizing to paint
  logic         sz_valid, sz_ready, sz_ok;
  pix_t         sz_pix;
  logic [U-1:0] sz_bx, sz_ex, sz_by, sz_ey;
  logic [U-1:0] sz_xl_len, sz_xr_len, sz_xl_thk, sz_xr_thk;
  logic [U-1:0] sz_yt_len, sz_yb_len, sz_yt_thk, sz_yb_thk;

  bocb_size #(.COORD_BITS(COORD_BITS)) u_size (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (box_valid),
    .in_ready_o  (box_ready),
    .pix_i       (box_pix),
    .box_ok_i    (box_ok),
    .bx_i        (box_bx),
    .ex_i        (box_ex),
    .by_i        (box_by),
    .ey_i        (box_ey),
    .side_i      (box_side),
    .out_valid_o (sz_valid),
    .out_ready_i (sz_ready),
    .pix_o       (sz_pix),
    .box_ok_o    (sz_ok),
    .bx_o        (sz_bx),
    .ex_o        (sz_ex),
    .by_o        (sz_by),
    .ey_o        (sz_ey),
    .xl_len_o    (sz_xl_len),
    .xr_len_o    (sz_xr_len),
    .xl_thk_o    (sz_xl_thk),
    .xr_thk_o    (sz_xr_thk),
    .yt_len_o    (sz_yt_len),
    .yb_len_o    (sz_yb_len),
    .yt_thk_o    (sz_yt_thk),
    .yb_thk_o    (sz_yb_thk)
  );

  // Hit test, blend and output register
  bocb_paint #(.COORD_BITS(COORD_BITS)) u_paint (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .warn_i      (warn_q),
    .in_valid_i  (sz_valid),
    .in_ready_o  (sz_ready),
    .pix_i       (sz_pix),
    .box_ok_i    (sz_ok),
    .bx_i        (sz_bx),
    .ex_i        (sz_ex),
    .by_i        (sz_by),
    .ey_i        (sz_ey),
    .xl_len_i    (sz_xl_len),
    .xr_len_i    (sz_xr_len),
    .xl_thk_i    (sz_xl_thk),
    .xr_thk_i    (sz_xr_thk),
    .yt_len_i    (sz_yt_len),
    .yb_len_i    (sz_yb_len),
    .yt_thk_i    (sz_yt_thk),
    .yb_thk_i    (sz_yb_thk),
    .out_valid_o (pix_out.valid),
    .out_ready_i (pix_out.ready),
    .rgb_o       (pix_out.data)
  );

endmodule
